>>> src/presence_debounce_table_defines.svh
// Assertion macros for the presence debounce table.
// Each use expects clk_i and rst_ni in scope.
`ifndef PRESENCE_DEBOUNCE_TABLE_DEFINES_SVH
`define PRESENCE_DEBOUNCE_TABLE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define PDT_ASSERT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);
// Next-cycle implication.
`define PDT_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);
`else
`define PDT_ASSERT(lbl, ant, con, msg)
`define PDT_ASSERT_NEXT(lbl, ant, con, msg)
`endif

`endif

>>> src/pdt_pkg.sv
package pdt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned NFOUND_W        = $clog2(MAX_RESULTS + 1);

  localparam int unsigned THR_W     = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [THR_W-1:0] THR_RESET = 3'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_THR   = 1'd1;

  // command codes
  localparam logic [1:0] CMD_DETECT = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_SCAN   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DETECT = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_SCAN   = 2'd2;

  // detect status codes
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_ADDED = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  pin;
    logic [63:0] address;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  out_pin;
    logic [63:0] out_address;
    logic        entry_valid;
    logic [1:0]  status;
    logic [4:0]  entries_in_use;
    logic        last;
  } res_word_t;

  typedef struct packed {
    logic [5:0]        pin;
    logic [63:0]       address;
    logic signed [3:0] count;
  } entry_t;

endpackage

>>> src/pdt_stream_if.sv
interface pdt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/presence_debounce_table.sv
// Channel   Dir  Modport  Word                               Accept
// cmd_i     in   sink     command, pin, address              valid && ready
// res_o     out  source   kind .. entries_in_use, last       valid && ready
// cfg_*     in   -        register index and 3-bit value     cfg_we_i
//
// Each table entry takes a memory read state and an evaluate state on the
// single registered read port of the entry memory. Detect stops at the
// matching entry or walks every used entry on a miss; report and scan walk all.
// Reset clears the fill count and seen bits; entry memory is never cleared.
// Input is taken only in idle; a full output register stalls the report walk and the final result.
module presence_debounce_table #(
  parameter int unsigned TABLE_DEPTH = pdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pdt_pkg::THR_W-1:0]      cfg_data_i,
  pdt_stream_if.sink                     cmd_i,
  pdt_stream_if.source                   res_o
);
  import pdt_pkg::*;

`include "presence_debounce_table_defines.svh"

  localparam int unsigned IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EV, S_EMIT} state_e;

  state_e                state_q, state_d;
  logic [CNTW-1:0]       idx_q, idx_d;     // read position
  logic [CNTW-1:0]       wr_q, wr_d;       // compaction write position
  logic [CNTW-1:0]       used_q, used_d;
  logic [TABLE_DEPTH-1:0] seen_q, seen_d;
  logic [1:0]            cmd_q, cmd_d;
  logic [5:0]            pin_q, pin_d;
  logic [63:0]           addr_q, addr_d;
  logic [1:0]            stat_q, stat_d;
  logic [THR_W-1:0]      dthr_q, dthr_d;
  logic [THR_W-1:0]      mthr_q, mthr_d;
  logic [NFOUND_W-1:0]   nfound_q, nfound_d;
  logic                  pend_v_q, pend_v_d;  // stable entry held back for last flag
  logic [5:0]            pend_pin_q, pend_pin_d;
  logic [63:0]           pend_addr_q, pend_addr_d;
  logic                  ov_q, ov_d;
  res_word_t             ores_q, ores_d;

  entry_t                entry_mem_q [TABLE_DEPTH];
  entry_t                rd_q;
  logic                  mem_we;
  logic [IDXW-1:0]       mem_waddr;
  entry_t                mem_wdata;

  logic                  out_free;
  logic signed [3:0]     dthr_s;
  logic signed [3:0]     floor_s;
  logic [31:0]           used_ext;
  logic [TABLE_DEPTH-1:0] in_use_mask;

  assign out_free    = !ov_q || res_o.ready;
  assign dthr_s      = $signed({1'b0, dthr_q});
  assign floor_s     = 4'sd0 - $signed({1'b0, mthr_q});
  assign used_ext    = 32'(used_q);
  assign cmd_i.ready = (state_q == S_IDLE);
  assign res_o.valid = ov_q;
  assign res_o.data  = ores_q;

  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      in_use_mask[k] = (CNTW'(k) < used_q);
    end
  end

  // Entry memory: one write port, one registered read port at idx_q.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= entry_mem_q[idx_q[IDXW-1:0]];
  end

  always_comb begin
    logic              ld;
    res_word_t         ld_res;
    logic              match;
    logic              stable;
    logic signed [3:0] cnt;

    state_d     = state_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    used_d      = used_q;
    seen_d      = seen_q;
    cmd_d       = cmd_q;
    pin_d       = pin_q;
    addr_d      = addr_q;
    stat_d      = stat_q;
    dthr_d      = dthr_q;
    mthr_d      = mthr_q;
    nfound_d    = nfound_q;
    pend_v_d    = pend_v_q;
    pend_pin_d  = pend_pin_q;
    pend_addr_d = pend_addr_q;
    ores_d      = ores_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_q[IDXW-1:0];
    mem_wdata   = rd_q;
    ld          = 1'b0;
    ld_res      = '0;
    ld_res.entries_in_use = used_ext[4:0];
    match       = (rd_q.pin == pin_q) && (rd_q.address == addr_q);
    stable      = (rd_q.pin == pin_q) && (rd_q.count >= dthr_s) &&
                  (nfound_q < NFOUND_W'(MAX_RESULTS));
    cnt         = rd_q.count;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DETECT_THR: dthr_d = cfg_data_i;
        REG_MISS_THR:   mthr_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d    = cmd_i.data.command;
          pin_d    = cmd_i.data.pin;
          addr_d   = cmd_i.data.address;
          idx_d    = '0;
          wr_d     = '0;
          nfound_d = '0;
          pend_v_d = 1'b0;
          stat_d   = ST_FOUND;
          case (cmd_i.data.command)
            CMD_DETECT, CMD_REPORT, CMD_SCAN: state_d = S_RD;
            default:                          state_d = S_IDLE;  // drop unused code
          endcase
        end
      end

      S_RD: begin
        if (idx_q == used_q) begin
          // walk done: finish the command
          state_d = S_EMIT;
          case (cmd_q)
            CMD_DETECT: begin
              if (used_q == CNTW'(TABLE_DEPTH)) begin
                stat_d = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = used_q[IDXW-1:0];
                mem_wdata.pin     = pin_q;
                mem_wdata.address = addr_q;
                mem_wdata.count   = 4'sd1;
                seen_d[used_q[IDXW-1:0]] = 1'b1;
                used_d          = used_q + CNTW'(1);
                stat_d          = ST_ADDED;
              end
            end
            CMD_SCAN: begin
              used_d = wr_q;
              seen_d = '0;
            end
            default: ;
          endcase
        end else begin
          state_d = S_EV;
        end
      end

      S_EV: begin
        case (cmd_q)
          CMD_DETECT: begin
            if (match) begin
              mem_we    = 1'b1;
              mem_waddr = idx_q[IDXW-1:0];
              if (rd_q.count < dthr_s) begin
                mem_wdata.count = rd_q.count + 4'sd1;
              end
              seen_d[idx_q[IDXW-1:0]] = 1'b1;
              stat_d  = ST_FOUND;
              state_d = S_EMIT;
            end else begin
              idx_d   = idx_q + CNTW'(1);
              state_d = S_RD;
            end
          end
          CMD_REPORT: begin
            if (stable && pend_v_q && !out_free) begin
              state_d = S_EV;  // hold until the output register frees up
            end else begin
              if (stable) begin
                if (pend_v_q) begin
                  ld                 = 1'b1;
                  ld_res.kind        = KIND_REPORT;
                  ld_res.out_pin     = pend_pin_q;
                  ld_res.out_address = pend_addr_q;
                  ld_res.entry_valid = 1'b1;
                end
                pend_v_d    = 1'b1;
                pend_pin_d  = rd_q.pin;
                pend_addr_d = rd_q.address;
                nfound_d    = nfound_q + NFOUND_W'(1);
              end
              idx_d   = idx_q + CNTW'(1);
              state_d = S_RD;
            end
          end
          default: begin
            // end of scan: age unseen entries, compact the survivors
            if (!seen_q[idx_q[IDXW-1:0]] && (cnt > floor_s)) begin
              cnt = cnt - 4'sd1;
            end
            if (cnt > floor_s) begin
              mem_we          = 1'b1;
              mem_waddr       = wr_q[IDXW-1:0];
              mem_wdata.count = cnt;
              wr_d            = wr_q + CNTW'(1);
            end
            idx_d   = idx_q + CNTW'(1);
            state_d = S_RD;
          end
        endcase
      end

      S_EMIT: begin
        if (out_free) begin
          ld          = 1'b1;
          ld_res.last = 1'b1;
          case (cmd_q)
            CMD_DETECT: begin
              ld_res.kind   = KIND_DETECT;
              ld_res.status = stat_q;
            end
            CMD_REPORT: begin
              ld_res.kind = KIND_REPORT;
              if (pend_v_q) begin
                ld_res.out_pin     = pend_pin_q;
                ld_res.out_address = pend_addr_q;
                ld_res.entry_valid = 1'b1;
              end
            end
            default: ld_res.kind = KIND_SCAN;
          endcase
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (ld) begin
      ores_d = ld_res;
    end
    ov_d = ld || (ov_q && !res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      wr_q        <= '0;
      used_q      <= '0;
      seen_q      <= '0;
      cmd_q       <= CMD_DETECT;
      pin_q       <= '0;
      addr_q      <= '0;
      stat_q      <= ST_FOUND;
      dthr_q      <= THR_RESET;
      mthr_q      <= THR_RESET;
      nfound_q    <= '0;
      pend_v_q    <= 1'b0;
      pend_pin_q  <= '0;
      pend_addr_q <= '0;
      ov_q        <= 1'b0;
      ores_q      <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      wr_q        <= wr_d;
      used_q      <= used_d;
      seen_q      <= seen_d;
      cmd_q       <= cmd_d;
      pin_q       <= pin_d;
      addr_q      <= addr_d;
      stat_q      <= stat_d;
      dthr_q      <= dthr_d;
      mthr_q      <= mthr_d;
      nfound_q    <= nfound_d;
      pend_v_q    <= pend_v_d;
      pend_pin_q  <= pend_pin_d;
      pend_addr_q <= pend_addr_d;
      ov_q        <= ov_d;
      ores_q      <= ores_d;
    end
  end

  `PDT_ASSERT(a_used_bound, 1'b1, used_q <= CNTW'(TABLE_DEPTH), "fill count past depth")
  `PDT_ASSERT(a_seen_in_use, 1'b1, (seen_q & ~in_use_mask) == '0, "seen bit on free entry")
  `PDT_ASSERT(a_compact_order, state_q == S_EV, wr_q <= idx_q, "compaction overtook read")
  `PDT_ASSERT_NEXT(a_busy_after_accept, cmd_i.valid && cmd_i.ready && (cmd_i.data.command == CMD_DETECT || cmd_i.data.command == CMD_REPORT || cmd_i.data.command == CMD_SCAN), !cmd_i.ready, "took word while busy")

endmodule
